[rtl/kauf_pkg.sv]
// ----------------------------------------------------------------------------
// kauf_pkg
// Shared types, constants and header byte lookup for the KISS AX.25 UI framer.
// ----------------------------------------------------------------------------
package kauf_pkg;

	localparam int unsigned BYTE_W         = 8;
	localparam int unsigned CALL_W         = 48;
	localparam int unsigned SSID_W         = 4;
	localparam int unsigned CFG_W          = CALL_W;
	localparam int unsigned REG_IDX_W      = 2;
	localparam int unsigned HDR_LEN        = 16;
	localparam int unsigned HIDX_W         = $clog2(HDR_LEN);
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_DEST_CALL = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_DEST_SSID = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_SRC_CALL  = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_SRC_SSID  = 2'd3;

	// reset values
	localparam logic [CALL_W-1:0] CALL_RESET = 48'h2020_2020_2020;
	localparam logic [SSID_W-1:0] SSID_RESET = 4'd0;

	// KISS and AX.25 codes
	localparam logic [BYTE_W-1:0] FEND      = 8'hC0;
	localparam logic [BYTE_W-1:0] FESC      = 8'hDB;
	localparam logic [BYTE_W-1:0] TFEND     = 8'hDC;
	localparam logic [BYTE_W-1:0] TFESC     = 8'hDD;
	localparam logic [BYTE_W-1:0] KISS_PORT = 8'h00;
	localparam logic [BYTE_W-1:0] SSID_BASE = 8'h60;
	localparam logic [BYTE_W-1:0] UI_CTRL   = 8'h03;
	localparam logic [BYTE_W-1:0] PID_NONE  = 8'hF0;
	localparam logic [BYTE_W-1:0] LOWER_A   = 8'h61;
	localparam logic [BYTE_W-1:0] LOWER_Z   = 8'h7A;
	localparam logic [BYTE_W-1:0] CASE_OFS  = 8'h20;

	typedef struct packed {
		logic [CALL_W-1:0] to_callsign;
		logic [SSID_W-1:0] dest_ssid;
		logic [CALL_W-1:0] from_callsign;
		logic [SSID_W-1:0] src_ssid;
	} cfg_t;

	// one queued item: payload byte plus what the back end must add
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              seg_end;
		logic              start;
	} cmd_t;

	// upper-case and shift one callsign character
	function automatic logic [BYTE_W-1:0] addr_char(input logic [BYTE_W-1:0] c);
		logic [BYTE_W-1:0] u;
		u = (c >= LOWER_A && c <= LOWER_Z) ? c - CASE_OFS : c;
		return {u[BYTE_W-2:0], 1'b0};
	endfunction

	// ssid octet, last flag in bit 0
	function automatic logic [BYTE_W-1:0] ssid_octet(input logic [SSID_W-1:0] ssid,
			input logic last);
		return SSID_BASE | {3'b000, ssid, last};
	endfunction

	// header byte at position idx, before escaping
	function automatic logic [BYTE_W-1:0] hdr_byte(input logic [HIDX_W-1:0] idx,
			input cfg_t cfg);
		logic [BYTE_W-1:0] b;
		case (idx)
			4'd0:  b = addr_char(cfg.to_callsign[47:40]);
			4'd1:  b = addr_char(cfg.to_callsign[39:32]);
			4'd2:  b = addr_char(cfg.to_callsign[31:24]);
			4'd3:  b = addr_char(cfg.to_callsign[23:16]);
			4'd4:  b = addr_char(cfg.to_callsign[15:8]);
			4'd5:  b = addr_char(cfg.to_callsign[7:0]);
			4'd6:  b = ssid_octet(cfg.dest_ssid, 1'b0);
			4'd7:  b = addr_char(cfg.from_callsign[47:40]);
			4'd8:  b = addr_char(cfg.from_callsign[39:32]);
			4'd9:  b = addr_char(cfg.from_callsign[31:24]);
			4'd10: b = addr_char(cfg.from_callsign[23:16]);
			4'd11: b = addr_char(cfg.from_callsign[15:8]);
			4'd12: b = addr_char(cfg.from_callsign[7:0]);
			4'd13: b = ssid_octet(cfg.src_ssid, 1'b1);
			4'd14: b = UI_CTRL;
			default: b = PID_NONE;
		endcase
		return b;
	endfunction

endpackage

[rtl/kauf_ifs.sv]
// ----------------------------------------------------------------------------
// kauf_ifs
// Valid/ready channels: segment bytes in, KISS line bytes out.
// ----------------------------------------------------------------------------
interface kauf_seg_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       segment_end;

	modport source(output valid, output payload_byte, output segment_end, input ready);
	modport sink(input valid, input payload_byte, input segment_end, output ready);
endinterface

interface kauf_line_if;
	logic       valid;
	logic       ready;
	logic [7:0] line_byte;
	logic       frame_close;
	logic       run_last;

	modport source(output valid, output line_byte, output frame_close, output run_last,
		input ready);
	modport sink(input valid, input line_byte, input frame_close, input run_last,
		output ready);
endinterface

[rtl/kauf_queue.sv]
// ----------------------------------------------------------------------------
// kauf_queue
// Short flop queue of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module kauf_queue #(
	parameter int unsigned DEPTH = kauf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  kauf_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output kauf_pkg::cmd_t head
);
	import kauf_pkg::*;

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cmd_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/kauf_front.sv]
// ----------------------------------------------------------------------------
// kauf_front
// Accepts segment bytes and tags each with whether it opens a new frame.
// ----------------------------------------------------------------------------
module kauf_front (
	input  logic           clk,
	input  logic           arst_n,
	kauf_seg_if.sink       seg,
	input  logic           full,
	output logic           push,
	output kauf_pkg::cmd_t push_cmd
);
	import kauf_pkg::*;

	logic frame_open_q;

	assign seg.ready        = !full;
	assign push             = seg.valid && !full;
	assign push_cmd.data    = seg.payload_byte;
	assign push_cmd.seg_end = seg.segment_end;
	assign push_cmd.start   = !frame_open_q;

	// frame tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
		end else if (push) begin
			frame_open_q <= !seg.segment_end;
		end
	end

endmodule

[rtl/kauf_back.sv]
// ----------------------------------------------------------------------------
// kauf_back
// Sequencer: open, port, header, escaped payload, close; a byte a cycle if ready.
// ----------------------------------------------------------------------------
module kauf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  kauf_pkg::cfg_t cfg,
	input  logic           not_empty,
	input  kauf_pkg::cmd_t head,
	output logic           pop,
	kauf_line_if.source    line
);
	import kauf_pkg::*;

	typedef enum logic [2:0] {
		PH_OPEN,
		PH_PORT,
		PH_HDR,
		PH_DATA,
		PH_CLOSE
	} phase_t;

	phase_t            phase_q;
	logic              busy_q;
	logic              esc2_q;
	logic [HIDX_W-1:0] hidx_q;
	cmd_t              cur_q;

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_close_q;
	logic              out_last_q;

	logic [BYTE_W-1:0] raw;
	logic              escapable;
	logic              needs_esc;
	logic [BYTE_W-1:0] emit;
	logic              advance;
	logic              step_last;

	// raw byte of the current step
	always_comb begin
		case (phase_q)
			PH_OPEN:  raw = FEND;
			PH_PORT:  raw = KISS_PORT;
			PH_HDR:   raw = hdr_byte(hidx_q, cfg);
			PH_DATA:  raw = cur_q.data;
			PH_CLOSE: raw = FEND;
			default:  raw = FEND;
		endcase
	end

	// escaping
	assign escapable = (phase_q == PH_HDR) || (phase_q == PH_DATA);
	assign needs_esc = escapable && (raw == FEND || raw == FESC);
	always_comb begin
		if (esc2_q) begin
			emit = (raw == FEND) ? TFEND : TFESC;
		end else if (needs_esc) begin
			emit = FESC;
		end else begin
			emit = raw;
		end
	end

	assign advance   = busy_q && (!out_valid_q || line.ready);
	assign step_last = (!needs_esc || esc2_q)
		&& ((phase_q == PH_CLOSE) || (phase_q == PH_DATA && !cur_q.seg_end));
	assign pop       = not_empty && (!busy_q || (advance && step_last));

	// sequencer state, current item and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_OPEN;
			busy_q      <= 1'b0;
			esc2_q      <= 1'b0;
			hidx_q      <= '0;
			cur_q       <= '0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_close_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				out_byte_q  <= emit;
				out_close_q <= (phase_q == PH_CLOSE);
				out_last_q  <= step_last;
			end else if (line.ready) begin
				out_valid_q <= 1'b0;
			end

			if (pop) begin
				busy_q  <= 1'b1;
				esc2_q  <= 1'b0;
				hidx_q  <= '0;
				cur_q   <= head;
				phase_q <= head.start ? PH_OPEN : PH_DATA;
			end else if (advance) begin
				if (needs_esc && !esc2_q) begin
					esc2_q <= 1'b1;
				end else begin
					esc2_q <= 1'b0;
					case (phase_q)
						PH_OPEN: phase_q <= PH_PORT;
						PH_PORT: phase_q <= PH_HDR;
						PH_HDR: begin
							if (hidx_q == HIDX_W'(HDR_LEN - 1)) begin
								phase_q <= PH_DATA;
							end
							hidx_q <= hidx_q + 1'b1;
						end
						PH_DATA: begin
							if (cur_q.seg_end) begin
								phase_q <= PH_CLOSE;
							end else begin
								busy_q <= 1'b0;
							end
						end
						default: busy_q <= 1'b0;
					endcase
				end
			end
		end
	end

	assign line.valid       = out_valid_q;
	assign line.line_byte   = out_byte_q;
	assign line.frame_close = out_close_q;
	assign line.run_last    = out_last_q;

endmodule

[rtl/kiss_ax25_ui_framer.sv]
// ----------------------------------------------------------------------------
// kiss_ax25_ui_framer
// Wraps segment payload bytes into KISS-escaped AX.25 UI frames.
// ----------------------------------------------------------------------------
// Usage:
//   seg  (sink)  : payload bytes, segment_end set on the last byte of a segment.
//   line (source): KISS line bytes; frame_close marks the closing FEND,
//                  run_last marks the final byte produced for an input item.
//   wr_en/wr_index/wr_data set the callsigns and SSIDs; write only while idle.
// An item is accepted at the first edge it is offered while the queue has room.
// The back end sends one line byte per cycle unless line.ready stalls it:
// a plain payload byte gives 1 line byte, an escaped one 2, a segment end adds
// 1, and a frame's first byte adds FEND, port byte and the 16-byte header (18
// to 30 bytes, so at most 33 for one item). An item passes the queue, current
// item and output registers. When line.ready is low the output register holds;
// the queue keeps taking items until it is full, then seg.ready drops.
// Reset clears the queue, the sequencer and the open-frame flag, and loads
// the default callsigns (six spaces) and SSID 0.
// ----------------------------------------------------------------------------
module kiss_ax25_ui_framer #(
	parameter int unsigned QUEUE_DEPTH = kauf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	kauf_seg_if.sink                          seg,
	kauf_line_if.source                       line,
	input  logic                              wr_en,
	input  logic [kauf_pkg::REG_IDX_W-1:0]    wr_index,
	input  logic [kauf_pkg::CFG_W-1:0]        wr_data
);
	import kauf_pkg::*;

	cfg_t cfg_q;
	cmd_t push_cmd;
	cmd_t head;
	logic push;
	logic pop;
	logic full;
	logic not_empty;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.to_callsign   <= CALL_RESET;
			cfg_q.dest_ssid     <= SSID_RESET;
			cfg_q.from_callsign <= CALL_RESET;
			cfg_q.src_ssid      <= SSID_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_DEST_CALL: cfg_q.to_callsign   <= wr_data;
				REG_DEST_SSID: cfg_q.dest_ssid     <= wr_data[SSID_W-1:0];
				REG_SRC_CALL:  cfg_q.from_callsign <= wr_data;
				REG_SRC_SSID:  cfg_q.src_ssid      <= wr_data[SSID_W-1:0];
				default: ;
			endcase
		end
	end

	kauf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.seg      (seg),
		.full     (full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	kauf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	kauf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop),
		.line      (line)
	);

`ifndef SYNTHESIS
	// closing FEND is always a raw FEND and ends its item
	a_close_fend: assert property (@(posedge clk) disable iff (!arst_n)
		line.valid && line.frame_close |-> line.line_byte == FEND && line.run_last)
		else $error("frame close without FEND");

	// an escape lead-in byte is never the last byte of an item
	a_fesc_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		line.valid && line.line_byte == FESC |-> !line.run_last && !line.frame_close)
		else $error("escape sequence cut short");

	// queue never pops while empty
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");
`endif

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the KISS AX.25 UI framer. A directed table of
// segment bytes and register writes comes first, then random segments under
// several callsign settings. Every line byte is compared with an in-bench
// frame builder that tracks the callsigns and the open-frame state.
// ----------------------------------------------------------------------------
module tb_top;
	import kauf_pkg::*;

	localparam int RAND_PHASES  = 6;
	localparam int PHASE_ITEMS  = 75;
	localparam int IDLE_PCT     = 11;
	localparam int QUIET_CYCLES = 4;
	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = 40;
	localparam int DIR_ROWS     = 35;

	typedef struct packed {
		logic [BYTE_W-1:0] line_byte;
		logic              frame_close;
		logic              run_last;
	} line_res_t;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

	// one directed step: a payload item or a register write
	typedef struct packed {
		row_kind_t            kind;
		logic [REG_IDX_W-1:0] reg_index;
		logic [CFG_W-1:0]     reg_value;
		logic [BYTE_W-1:0]    data;
		logic                 seg_end;
		logic [5:0]           exp_count;
		logic [BYTE_W-1:0]    exp_tail;
	} row_t;

	// exp_count of zero: checked against the frame builder only
	row_t dir_rows [DIR_ROWS] = '{
		// default callsigns: 2 + 16 header bytes around each new frame
		'{ROW_ITEM, REG_DEST_CALL, 48'h0, 8'h41, 1'b1, 6'd20, FEND},
		'{ROW_ITEM, REG_DEST_CALL, 48'h0, 8'h00, 1'b0, 6'd19, 8'h00},
		'{ROW_ITEM, REG_DEST_CALL, 48'h0, 8'hFF, 1'b0, 6'd1,  8'hFF},
		'{ROW_ITEM, REG_DEST_CALL, 48'h0, FEND,  1'b0, 6'd2,  TFEND},
		'{ROW_ITEM, REG_DEST_CALL, 48'h0, FESC,  1'b0, 6'd2,  TFESC},
		'{ROW_ITEM, REG_DEST_CALL, 48'h0, TFEND, 1'b0, 6'd1,  TFEND},
		'{ROW_ITEM, REG_DEST_CALL, 48'h0, TFESC, 1'b1, 6'd2,  FEND},
		// frame left open across a register change
		'{ROW_ITEM, REG_DEST_CALL, 48'h0, 8'h7F, 1'b0, 6'd19, 8'h7F},
		'{ROW_REG,  REG_DEST_CALL, 48'h6E6F_6361_6C6C, 8'h00, 1'b0, 6'd0, 8'h00},
		'{ROW_REG,  REG_DEST_SSID, 48'hFFFF_FFFF_FFF5, 8'h00, 1'b0, 6'd0, 8'h00},
		'{ROW_REG,  REG_SRC_CALL,  48'h4E30_4341_4C4C, 8'h00, 1'b0, 6'd0, 8'h00},
		'{ROW_REG,  REG_SRC_SSID,  48'h0000_0000_0007, 8'h00, 1'b0, 6'd0, 8'h00},
		'{ROW_ITEM, REG_DEST_CALL, 48'h0, 8'h80, 1'b1, 6'd2,  FEND},
		'{ROW_ITEM, REG_DEST_CALL, 48'h0, 8'h5A, 1'b1, 6'd0,  8'h00},
		// every callsign character encodes to FEND: largest frames
		'{ROW_REG,  REG_DEST_CALL, 48'h60E0_60E0_60E0, 8'h00, 1'b0, 6'd0, 8'h00},
		'{ROW_REG,  REG_DEST_SSID, 48'h0000_0000_000F, 8'h00, 1'b0, 6'd0, 8'h00},
		'{ROW_REG,  REG_SRC_CALL,  48'hE060_E060_E060, 8'h00, 1'b0, 6'd0, 8'h00},
		'{ROW_REG,  REG_SRC_SSID,  48'h0000_0000_000F, 8'h00, 1'b0, 6'd0, 8'h00},
		'{ROW_ITEM, REG_DEST_CALL, 48'h0, FESC,  1'b1, 6'd33, FEND},
		'{ROW_ITEM, REG_DEST_CALL, 48'h0, 8'h01, 1'b0, 6'd31, 8'h01},
		'{ROW_ITEM, REG_DEST_CALL, 48'h0, FEND,  1'b1, 6'd3,  FEND},
		// all-zero and all-ones callsigns
		'{ROW_REG,  REG_DEST_CALL, 48'h0000_0000_0000, 8'h00, 1'b0, 6'd0, 8'h00},
		'{ROW_REG,  REG_DEST_SSID, 48'h0000_0000_0000, 8'h00, 1'b0, 6'd0, 8'h00},
		'{ROW_REG,  REG_SRC_CALL,  48'hFFFF_FFFF_FFFF, 8'h00, 1'b0, 6'd0, 8'h00},
		'{ROW_REG,  REG_SRC_SSID,  48'h0000_0000_0000, 8'h00, 1'b0, 6'd0, 8'h00},
		'{ROW_ITEM, REG_DEST_CALL, 48'h0, 8'h00, 1'b1, 6'd20, FEND},
		'{ROW_REG,  REG_DEST_CALL, 48'hFFFF_FFFF_FFFF, 8'h00, 1'b0, 6'd0, 8'h00},
		'{ROW_REG,  REG_DEST_SSID, 48'h0000_0000_000F, 8'h00, 1'b0, 6'd0, 8'h00},
		'{ROW_REG,  REG_SRC_CALL,  48'h0000_0000_0000, 8'h00, 1'b0, 6'd0, 8'h00},
		'{ROW_ITEM, REG_DEST_CALL, 48'h0, 8'hFF, 1'b1, 6'd20, FEND},
		// lower-case edges and their neighbors
		'{ROW_REG,  REG_DEST_CALL, 48'h617A_6061_7B40, 8'h00, 1'b0, 6'd0, 8'h00},
		'{ROW_REG,  REG_SRC_CALL,  48'h415A_2030_3939, 8'h00, 1'b0, 6'd0, 8'h00},
		'{ROW_ITEM, REG_DEST_CALL, 48'h0, 8'h42, 1'b0, 6'd0,  8'h00},
		'{ROW_ITEM, REG_DEST_CALL, 48'h0, FEND,  1'b0, 6'd0,  8'h00},
		'{ROW_ITEM, REG_DEST_CALL, 48'h0, FESC,  1'b1, 6'd0,  8'h00}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [CFG_W-1:0]     wr_data;

	kauf_seg_if  seg_bus();
	kauf_line_if line_bus();

	kiss_ax25_ui_framer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.seg      (seg_bus),
		.line     (line_bus),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// frame builder state
	cfg_t      shadow_cfg;
	logic      frame_busy;
	line_res_t line_due[$];

	int fail_count    = 0;
	int items_sent    = 0;
	int lines_checked = 0;
	int frames_closed = 0;
	int reg_writes    = 0;
	int max_burst     = 0;
	int hold_left     = 0;
	bit steady        = 1'b0;
	bit hold_req      = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void note_mismatch(input string what, input logic [BYTE_W-1:0] want,
			input logic [BYTE_W-1:0] got);
		fail_count++;
		$display("%0t: %s expected %h, got %h", $time, what, want, got);
	endfunction

	function automatic void queue_line(input logic [BYTE_W-1:0] b, input logic close);
		line_res_t r;
		r.line_byte   = b;
		r.frame_close = close;
		r.run_last    = 1'b0;
		line_due.push_back(r);
	endfunction

	// FEND and FESC go out as two-byte escapes
	function automatic void queue_escaped(input logic [BYTE_W-1:0] b);
		if (b == FEND) begin
			queue_line(FESC, 1'b0);
			queue_line(TFEND, 1'b0);
		end else if (b == FESC) begin
			queue_line(FESC, 1'b0);
			queue_line(TFESC, 1'b0);
		end else begin
			queue_line(b, 1'b0);
		end
	endfunction

	// callsign character: upper-case letters only, then shift left
	function automatic logic [BYTE_W-1:0] shifted_char(input logic [BYTE_W-1:0] c);
		logic [BYTE_W-1:0] up;
		up = c;
		if (c >= LOWER_A && c <= LOWER_Z)
			up = c - CASE_OFS;
		return {up[BYTE_W-2:0], 1'b0};
	endfunction

	function automatic void queue_address(input logic [CALL_W-1:0] call,
			input logic [SSID_W-1:0] ssid, input logic last);
		for (int i = 5; i >= 0; i--)
			queue_escaped(shifted_char(call[8*i +: 8]));
		queue_escaped(SSID_BASE | {3'b000, ssid, last});
	endfunction

	// line bytes caused by one payload item, returns how many
	function automatic int frame_item(input logic [BYTE_W-1:0] b, input logic last_byte);
		int before_n;
		before_n = line_due.size();
		if (!frame_busy) begin
			queue_line(FEND, 1'b0);
			queue_line(KISS_PORT, 1'b0);
			queue_address(shadow_cfg.to_callsign, shadow_cfg.dest_ssid, 1'b0);
			queue_address(shadow_cfg.from_callsign, shadow_cfg.src_ssid, 1'b1);
			queue_escaped(UI_CTRL);
			queue_escaped(PID_NONE);
			frame_busy = 1'b1;
		end
		queue_escaped(b);
		if (last_byte) begin
			queue_line(FEND, 1'b1);
			frame_busy = 1'b0;
		end
		line_due[line_due.size()-1].run_last = 1'b1;
		return line_due.size() - before_n;
	endfunction

	// payload biased toward the escape codes
	function automatic logic [BYTE_W-1:0] rand_payload();
		case ($urandom_range(15))
			0: return FEND;
			1: return FESC;
			2: return TFEND;
			3: return TFESC;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [BYTE_W-1:0] rand_call_char();
		case ($urandom_range(7))
			0: return 8'h41 + 8'($urandom_range(25));
			1: return LOWER_A + 8'($urandom_range(25));
			2: return 8'h30 + 8'($urandom_range(9));
			3: return 8'h20;
			4: return $urandom_range(1) ? 8'h60 : 8'hE0;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [CALL_W-1:0] rand_call();
		logic [CALL_W-1:0] c;
		for (int i = 0; i < 6; i++)
			c[8*i +: 8] = rand_call_char();
		return c;
	endfunction

	// one register write; enable stays high until the caller lowers it
	task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		case (idx)
			REG_DEST_CALL: shadow_cfg.to_callsign   = val;
			REG_DEST_SSID: shadow_cfg.dest_ssid     = val[SSID_W-1:0];
			REG_SRC_CALL:  shadow_cfg.from_callsign = val;
			REG_SRC_SSID:  shadow_cfg.src_ssid      = val[SSID_W-1:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	// stop offering, wait for every line byte, then a short quiet spell
	task automatic settle();
		seg_bus.valid <= 1'b0;
		while (line_due.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic send_item(input logic [BYTE_W-1:0] b, input logic last_byte,
			output int n_out);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			seg_bus.valid <= 1'b0;
			@(posedge clk);
		end
		seg_bus.valid        <= 1'b1;
		seg_bus.payload_byte <= b;
		seg_bus.segment_end  <= last_byte;
		@(posedge clk);
		while (!seg_bus.ready)
			@(posedge clk);
		n_out = frame_item(b, last_byte);
		items_sent++;
		if (n_out > max_burst)
			max_burst = n_out;
	endtask

	task automatic check_line();
		line_res_t want;
		if (line_due.size() == 0) begin
			fail_count++;
			$display("%0t: line byte %h with no item outstanding", $time,
				line_bus.line_byte);
		end else begin
			want = line_due.pop_front();
			lines_checked++;
			if (line_bus.line_byte !== want.line_byte)
				note_mismatch("line_byte", want.line_byte, line_bus.line_byte);
			if (line_bus.frame_close !== want.frame_close)
				note_mismatch("frame_close", {7'b0, want.frame_close},
					{7'b0, line_bus.frame_close});
			if (line_bus.run_last !== want.run_last)
				note_mismatch("run_last", {7'b0, want.run_last}, {7'b0, line_bus.run_last});
			if (want.frame_close)
				frames_closed++;
		end
	endtask

	// line side: check each line byte, random stalls, one long hold-off on request
	initial begin
		line_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (line_bus.valid === 1'b1 && line_bus.ready === 1'b1)
				check_line();
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				line_bus.ready <= 1'b0;
			end else begin
				line_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// stimulus
	initial begin
		int                n_out;
		int                seg_left;
		bit                cfg_open;
		logic [CFG_W-1:0]  call_d;
		logic [CFG_W-1:0]  call_s;
		logic [CFG_W-1:0]  ssid_d;
		logic [CFG_W-1:0]  ssid_s;

		arst_n               <= 1'b0;
		wr_en                <= 1'b0;
		wr_index             <= REG_DEST_CALL;
		wr_data              <= '0;
		seg_bus.valid        <= 1'b0;
		seg_bus.payload_byte <= '0;
		seg_bus.segment_end  <= 1'b0;
		shadow_cfg = {CALL_RESET, SSID_RESET, CALL_RESET, SSID_RESET};
		frame_busy = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		cfg_open = 1'b0;
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_rows[i].kind == ROW_REG) begin
				if (!cfg_open) begin
					settle();
					cfg_open = 1'b1;
				end
				reg_write(dir_rows[i].reg_index, dir_rows[i].reg_value);
			end else begin
				if (cfg_open) begin
					wr_en    <= 1'b0;
					cfg_open = 1'b0;
				end
				send_item(dir_rows[i].data, dir_rows[i].seg_end, n_out);
				if (dir_rows[i].exp_count != 0) begin
					if (n_out != int'(dir_rows[i].exp_count))
						note_mismatch("line bytes for table item", 8'(dir_rows[i].exp_count),
							8'(n_out));
					if (line_due[line_due.size()-1].line_byte !== dir_rows[i].exp_tail)
						note_mismatch("last line byte for table item", dir_rows[i].exp_tail,
							line_due[line_due.size()-1].line_byte);
				end
			end
		end

		// random segments; a segment may run on across a register change
		seg_left = 0;
		for (int p = 0; p < RAND_PHASES; p++) begin
			settle();
			case (p)
				0: begin
					call_d = '1;
					call_s = '1;
					ssid_d = '1;
					ssid_s = '1;
				end
				1: begin
					call_d = '0;
					call_s = '0;
					ssid_d = '0;
					ssid_s = '0;
				end
				default: begin
					call_d = rand_call();
					call_s = rand_call();
					ssid_d = {16'($urandom), $urandom};
					ssid_s = {16'($urandom), $urandom};
				end
			endcase
			reg_write(REG_DEST_CALL, call_d);
			reg_write(REG_DEST_SSID, ssid_d);
			reg_write(REG_SRC_CALL, call_s);
			reg_write(REG_SRC_SSID, ssid_s);
			wr_en <= 1'b0;

			// one phase without idling, one with a long line stall
			steady = (p == 2);
			if (p == 3)
				hold_req = 1'b1;

			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (seg_left == 0)
					seg_left = ($urandom_range(9) == 0) ? $urandom_range(40, 20)
						: $urandom_range(8, 1);
				send_item(rand_payload(), seg_left == 1, n_out);
				seg_left--;
			end
		end
		steady = 1'b0;

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("ran %0d payload items under %0d register writes", items_sent, reg_writes);
		$display("checked %0d line bytes in %0d closed frames, up to %0d from one item",
			lines_checked, frames_closed, max_burst);
		if (fail_count == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("%0t: timed out with %0d line bytes outstanding", $time, line_due.size());
		$display("tb_top failed");
		$finish;
	end

endmodule

[sim.f]
rtl/kauf_pkg.sv
rtl/kauf_ifs.sv
rtl/kauf_queue.sv
rtl/kauf_front.sv
rtl/kauf_back.sv
rtl/kiss_ax25_ui_framer.sv
tb/tb_top.sv
